// File: sv/nrgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrgs_pkg
// Shared types, constants and helpers for the n-run gap segmenter: the
// request and record structs, the front-to-back command and register codes.
// ----------------------------------------------------------------------------
package nrgs_pkg;

	// Width of positions and counters; results carry the low OUT_W bits.
	localparam int POS_BITS = 32;
	localparam int OUT_W    = 32;
	localparam int CMP_W    = (POS_BITS > OUT_W) ? POS_BITS : OUT_W;

	// Configuration port.
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_MIN_CONTIG_GAP   = 2'd0;
	localparam logic [1:0] REG_MIN_SCAFFOLD_GAP = 2'd1;
	localparam logic [1:0] REG_SINGLE_CONTIGS   = 2'd2;
	localparam logic [31:0] RST_MIN_CONTIG_GAP   = 32'd25;
	localparam logic [31:0] RST_MIN_SCAFFOLD_GAP = 32'd50000;

	// Lowercase n marks an unknown base.
	localparam logic [7:0] CHAR_UNKNOWN = 8'h6E;

	// Command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Record slots of one command, in output order.
	localparam int EMIT_PRE = 0;  // contig closed by the run
	localparam int EMIT_GAP = 1;  // the gap itself
	localparam int EMIT_END = 2;  // final contig of the sequence
	localparam int EMIT_N   = 3;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [EMIT_N-1:0]   emit_t;

	typedef struct packed {
		logic [7:0] base;
		logic       last_base;
	} in_item_t;

	typedef struct packed {
		logic             is_gap;
		logic [OUT_W-1:0] start_pos;
		logic [OUT_W-1:0] end_pos;
		logic [OUT_W-1:0] part_number;
		logic [OUT_W-1:0] contig_number;
		logic [OUT_W-1:0] seg_length;
		logic             scaffold_gap;
		logic             plain_name;
		logic             last_result;
	} out_item_t;

	typedef struct packed {
		logic [31:0] min_contig_gap;
		logic [31:0] min_scaffold_gap;
		logic        single_contigs;
	} cfg_t;

	// One classified request: which records it causes and their bounds.
	// The leading contig ends where the gap begins.
	typedef struct packed {
		emit_t emit;
		pos_t  pre_from;
		pos_t  gap_from;
		pos_t  gap_to;
		pos_t  end_from;
		pos_t  end_to;
		logic  end_plain;
		logic  seq_end;
	} cmd_t;

	// Low bits of a position or counter as a result field.
	function automatic logic [OUT_W-1:0] to_out(pos_t v);
		return OUT_W'(v);
	endfunction

	// Unsigned compare of a position difference against a 32-bit register.
	function automatic logic pos_ge(pos_t v, logic [31:0] lim);
		logic [CMP_W-1:0] a;
		logic [CMP_W-1:0] b;
		a = CMP_W'(v);
		b = CMP_W'(lim);
		return a >= b;
	endfunction

endpackage

// File: sv/n_run_gap_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_run_gap_segmenter
// Splits a base stream into contig and gap records at runs of lowercase n.
//
//   Channel   Direction  Handshake                 Payload
//   in        request    in_valid / in_ready        in_item  (in_item_t)
//   out       record     out_valid / out_ready      out_item (out_item_t)
//   cfg       APB write  psel, penable, pwrite      paddr, pwdata / prdata
//
// One base is taken per cycle while the command queue is not full; records
// pass through the command queue and the output register. The back end sends
// one record per cycle while out_ready holds; a base that closes a run and
// ends the sequence gives three records, which the four-entry command queue
// absorbs. Reset clears all sequence state and loads the register defaults;
// there is no clearing pass. in_ready falls only when the queue is full.
// ----------------------------------------------------------------------------
module n_run_gap_segmenter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  nrgs_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output nrgs_pkg::out_item_t         out_item,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nrgs_pkg::ADDR_W-1:0] paddr,
	input  logic [nrgs_pkg::DATA_W-1:0] pwdata,
	output logic [nrgs_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	nrgs_pkg::cfg_t cfg_q;
	nrgs_pkg::cmd_t push_cmd;
	nrgs_pkg::cmd_t head_cmd;
	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           head_valid;
	logic           cfg_write;
	logic [1:0]     reg_index;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_index = paddr[3:2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_contig_gap   <= nrgs_pkg::RST_MIN_CONTIG_GAP;
			cfg_q.min_scaffold_gap <= nrgs_pkg::RST_MIN_SCAFFOLD_GAP;
			cfg_q.single_contigs   <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_index)
				nrgs_pkg::REG_MIN_CONTIG_GAP: begin
					cfg_q.min_contig_gap <= pwdata;
				end
				nrgs_pkg::REG_MIN_SCAFFOLD_GAP: begin
					cfg_q.min_scaffold_gap <= pwdata;
				end
				nrgs_pkg::REG_SINGLE_CONTIGS: begin
					cfg_q.single_contigs <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_index)
			nrgs_pkg::REG_MIN_CONTIG_GAP:   prdata = cfg_q.min_contig_gap;
			nrgs_pkg::REG_MIN_SCAFFOLD_GAP: prdata = cfg_q.min_scaffold_gap;
			nrgs_pkg::REG_SINGLE_CONTIGS:   prdata = {31'b0, cfg_q.single_contigs};
			default:                        prdata = '0;
		endcase
	end

	nrgs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	nrgs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	nrgs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (head_valid),
		.q_cmd     (head_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// File: sv/nrgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrgs_front
// Takes one base per request, tracks the open contig and the run of unknown
// bases, and turns each request that causes records into a back-end command.
// ----------------------------------------------------------------------------
module nrgs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  nrgs_pkg::in_item_t in_item,
	input  nrgs_pkg::cfg_t    cfg,
	input  logic              q_full,
	output logic              q_push,
	output nrgs_pkg::cmd_t    q_cmd
);

	nrgs_pkg::pos_t pos_q;
	nrgs_pkg::pos_t contig_begin_q;
	nrgs_pkg::pos_t run_begin_q;
	logic           in_run_q;
	logic           seen_q;

	nrgs_pkg::pos_t next_pos;
	nrgs_pkg::pos_t run_len;
	nrgs_pkg::pos_t run_begin_nx;
	nrgs_pkg::pos_t contig_begin_nx;
	logic           is_unknown;
	logic           close_inner;
	logic           close_any;
	logic           accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the base against the run state.
	always_comb begin
		is_unknown      = (in_item.base == nrgs_pkg::CHAR_UNKNOWN);
		next_pos        = pos_q + 1'b1;
		run_len         = pos_q - run_begin_q;
		close_inner     = !is_unknown && in_run_q && nrgs_pkg::pos_ge(run_len, cfg.min_contig_gap);
		close_any       = close_inner || (in_item.last_base && is_unknown);
		run_begin_nx    = (is_unknown && !in_run_q) ? pos_q : run_begin_q;
		contig_begin_nx = close_inner ? pos_q : contig_begin_q;
	end

	// Build the command; at most a closed run plus the final contig.
	always_comb begin
		q_cmd                              = '0;
		q_cmd.emit[nrgs_pkg::EMIT_PRE]     = close_any && (run_begin_nx != contig_begin_q);
		q_cmd.emit[nrgs_pkg::EMIT_GAP]     = close_any;
		q_cmd.emit[nrgs_pkg::EMIT_END]     = in_item.last_base && !is_unknown;
		q_cmd.pre_from                     = contig_begin_q;
		q_cmd.gap_from                     = run_begin_nx;
		q_cmd.gap_to                       = is_unknown ? next_pos : pos_q;
		q_cmd.end_from                     = contig_begin_nx;
		q_cmd.end_to                       = next_pos;
		q_cmd.end_plain                    = cfg.single_contigs && !seen_q;
		q_cmd.seq_end                      = in_item.last_base;
		q_push                             = accept && (q_cmd.emit != '0);
	end

	// Sequence state; all of it returns to zero after the last base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			contig_begin_q <= '0;
			run_begin_q    <= '0;
			in_run_q       <= 1'b0;
			seen_q         <= 1'b0;
		end else if (accept) begin
			if (in_item.last_base) begin
				pos_q          <= '0;
				contig_begin_q <= '0;
				run_begin_q    <= '0;
				in_run_q       <= 1'b0;
				seen_q         <= 1'b0;
			end else begin
				pos_q          <= next_pos;
				contig_begin_q <= contig_begin_nx;
				run_begin_q    <= run_begin_nx;
				in_run_q       <= is_unknown;
				seen_q         <= seen_q || is_unknown;
			end
		end
	end

endmodule

// File: sv/nrgs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrgs_queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module nrgs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nrgs_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output nrgs_pkg::cmd_t head_cmd
);

	nrgs_pkg::cmd_t                mem_q [nrgs_pkg::QUEUE_DEPTH];
	logic [nrgs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [nrgs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [nrgs_pkg::QPTR_W:0]     count_q;

	assign full       = (count_q == (nrgs_pkg::QPTR_W+1)'(nrgs_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command pushed into a full queue");

	a_no_underflow : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command popped from an empty queue");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (nrgs_pkg::QPTR_W+1)'(nrgs_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond its depth");

endmodule

// File: sv/nrgs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrgs_back
// Walks the records of the head command, one per cycle while out_ready holds,
// numbers them, and holds each in an output register until it is taken.
// ----------------------------------------------------------------------------
module nrgs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  nrgs_pkg::cfg_t     cfg,
	input  logic               q_valid,
	input  nrgs_pkg::cmd_t     q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output nrgs_pkg::out_item_t out_item
);

	nrgs_pkg::out_item_t out_q;
	logic                out_valid_q;
	nrgs_pkg::emit_t     done_q;
	nrgs_pkg::pos_t      part_q;
	nrgs_pkg::pos_t      contig_q;

	nrgs_pkg::emit_t     rem;
	nrgs_pkg::emit_t     sel;
	nrgs_pkg::emit_t     rem_after;
	nrgs_pkg::pos_t      rec_from;
	nrgs_pkg::pos_t      rec_to;
	nrgs_pkg::pos_t      rec_len;
	nrgs_pkg::pos_t      part_nx;
	nrgs_pkg::pos_t      contig_nx;
	logic                rec_gap;
	logic                rec_plain;
	logic                load;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Pick the first record of the head command not yet sent.
	always_comb begin
		rem = q_valid ? (q_cmd.emit & ~done_q) : '0;
		sel = '0;
		if (rem[nrgs_pkg::EMIT_PRE]) begin
			sel[nrgs_pkg::EMIT_PRE] = 1'b1;
		end else if (rem[nrgs_pkg::EMIT_GAP]) begin
			sel[nrgs_pkg::EMIT_GAP] = 1'b1;
		end else if (rem[nrgs_pkg::EMIT_END]) begin
			sel[nrgs_pkg::EMIT_END] = 1'b1;
		end
		rem_after = rem & ~sel;
		load      = q_valid && (!out_valid_q || out_ready);
		q_pop     = load && (rem_after == '0);
	end

	// Bounds and kind of the selected record.
	always_comb begin
		rec_from  = q_cmd.end_from;
		rec_to    = q_cmd.end_to;
		rec_gap   = 1'b0;
		rec_plain = q_cmd.end_plain;
		if (sel[nrgs_pkg::EMIT_PRE]) begin
			rec_from  = q_cmd.pre_from;
			rec_to    = q_cmd.gap_from;
			rec_plain = 1'b0;
		end else if (sel[nrgs_pkg::EMIT_GAP]) begin
			rec_from  = q_cmd.gap_from;
			rec_to    = q_cmd.gap_to;
			rec_gap   = 1'b1;
			rec_plain = 1'b0;
		end
		rec_len   = rec_to - rec_from;
		part_nx   = part_q + 1'b1;
		contig_nx = contig_q + 1'b1;
	end

	// Output register; a new record loads as the old one leaves.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.is_gap        <= rec_gap;
			out_q.start_pos     <= nrgs_pkg::to_out(rec_from + 1'b1);
			out_q.end_pos       <= nrgs_pkg::to_out(rec_to);
			out_q.part_number   <= nrgs_pkg::to_out(part_nx);
			out_q.contig_number <= rec_gap ? '0 : nrgs_pkg::to_out(contig_nx);
			out_q.seg_length    <= nrgs_pkg::to_out(rec_len);
			out_q.scaffold_gap  <= rec_gap && nrgs_pkg::pos_ge(rec_len, cfg.min_scaffold_gap);
			out_q.plain_name    <= rec_plain;
			out_q.last_result   <= (rem_after == '0);
		end
	end

	// Control: valid flag, progress through the command, counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			done_q      <= '0;
			part_q      <= '0;
			contig_q    <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				part_q <= part_nx;
				if (q_pop) begin
					done_q <= '0;
				end else begin
					done_q <= done_q | sel;
				end
				if (q_pop && q_cmd.seq_end) begin
					contig_q <= '0;
				end else if (!rec_gap) begin
					contig_q <= contig_nx;
				end
			end
		end
	end

	a_load_has_record : assert property (@(posedge clk) disable iff (!arst_n)
		load |-> $onehot(sel))
		else $error("record loaded from a command with nothing left to send");

	a_part_steps : assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_q.part_number == nrgs_pkg::to_out($past(part_q) + 1'b1))
		else $error("part number did not advance by one");

	a_gap_fields : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_gap) |-> (out_q.contig_number == '0 && !out_q.plain_name))
		else $error("gap record carries contig fields");

	a_pop_ends_cmd : assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (done_q == '0 && out_q.last_result))
		else $error("command popped without its last record");

endmodule
